// File: src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while reset is high
`define PBHT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion, checked during reset too
`define PBHT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/pbht_pkg.sv
// types and constants of the packed bucket hash table
package pbht_pkg;

   localparam int KEY_W      = 64;
   localparam int VALUE_W    = 64;
   localparam int COUNT_W    = 15;
   localparam int BITS_W     = 4;
   localparam int MASKED_W   = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BITS_W-1:0] BIN_BITS_RESET = 4'd10;
   localparam logic CSR_BIN_INDEX_BITS = 1'b0;

   typedef enum logic [1:0] {
      MODE_GET    = 2'd0,
      MODE_PUT    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_ABSENT    = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_FILL,
      S_FWAIT,
      S_SCAN,
      S_WRITE,
      S_DONE
   } state_type;

endpackage

// File: src/pbht_if.sv
// request and response channel interfaces
interface pbht_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [pbht_pkg::KEY_W-1:0]    key;
   logic [pbht_pkg::VALUE_W-1:0]  value;
   modport source (output valid, mode, key, value, input ready);
   modport sink (input valid, mode, key, value, output ready);
endinterface

interface pbht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [pbht_pkg::VALUE_W-1:0]  value_out;
   logic [pbht_pkg::COUNT_W-1:0]  entry_count;
   modport source (output valid, status, value_out, entry_count, input ready);
   modport sink (input valid, status, value_out, entry_count, output ready);
endinterface

// File: src/packed_bucket_hash_table_top.sv
// packed bucket hash table: top level
//
// Requests arrive on req_chan (mode, key, value) with valid/ready; each one
// gives exactly one response on rsp_chan (status, value_out, entry_count).
// The bin of a key is its low bin_index_bits bits, reduced modulo NUM_BINS.
// One request is worked at a time. After accept a request passes the states
// FILL, FWAIT, SCAN and WRITE, SCAN reading the buckets of the bin one bucket
// per cycle from the slot memory (1 to BUCKETS_IN_CHAIN); DONE then loads the
// response register and returns to idle. When NUM_BINS is not a power of two
// a reciprocal-multiply modulo state MOD comes before FILL. A request of the
// unused mode goes straight to DONE.
// The response waits in an output register while rsp_chan.ready is low; the
// block completes its work and holds the next result until the register
// frees up.
// After reset the bin fill memory is cleared, one bin per cycle, with
// req_chan.ready low meanwhile. Slot contents are not cleared. bin_index_bits
// sits at byte address 0 of the csr port and resets to 10; the user must write
// it only while no request is in flight, which the block does not enforce.
module packed_bucket_hash_table_top #(
   parameter int NUM_BINS          = 1024,
   parameter int ENTRIES_IN_BUCKET = 4,
   parameter int BUCKETS_IN_CHAIN  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   pbht_req_if.sink                          req_chan,
   pbht_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pbht_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pbht_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pbht_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int RUN   = ENTRIES_IN_BUCKET * BUCKETS_IN_CHAIN;
   localparam int ROWS  = NUM_BINS * BUCKETS_IN_CHAIN;
   localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int FW    = $clog2(RUN + 1);
   localparam int LW    = (ENTRIES_IN_BUCKET > 1) ? $clog2(ENTRIES_IN_BUCKET) : 1;
   localparam int BCW   = $clog2(BUCKETS_IN_CHAIN + 1);
   localparam int CAP   = NUM_BINS * RUN;
   localparam int TW    = ($clog2(CAP + 1) > pbht_pkg::COUNT_W) ?
                          $clog2(CAP + 1) : pbht_pkg::COUNT_W;
   localparam bit POW2  = (NUM_BINS & (NUM_BINS - 1)) == 0;
   localparam int KVW   = pbht_pkg::KEY_W + pbht_pkg::VALUE_W;
   localparam int MW    = pbht_pkg::MASKED_W;
   localparam int RW    = 17;
   localparam logic [30:0] RECIP = 31'((64'd1 << 30) / NUM_BINS);

   pbht_pkg::state_type  state_ff, state_in;
   logic [pbht_pkg::BITS_W-1:0] bits_ff, bits_in;
   pbht_pkg::mode_type   mode_ff, mode_in;
   logic [pbht_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [pbht_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [MW-1:0]        masked_ff, masked_in;
   logic [RW-1:0]        mod_r_ff, mod_r_in;
   logic [3:0]           mod_cnt_ff, mod_cnt_in;
   logic [BW-1:0]        bin_ff, bin_in;
   logic [AW-1:0]        row_base_ff, row_base_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [BCW-1:0]       b_ff, b_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        hole_row_ff, hole_row_in;
   logic [LW-1:0]        hole_lane_ff, hole_lane_in;
   logic [pbht_pkg::VALUE_W-1:0] hit_val_ff, hit_val_in;
   logic [KVW-1:0]       last_kv_ff, last_kv_in;
   logic [AW-1:0]        put_row_ff, put_row_in;
   logic [LW-1:0]        put_lane_ff, put_lane_in;
   logic [BW-1:0]        clr_ff, clr_in;
   logic [TW-1:0]        total_ff, total_in;
   pbht_pkg::status_type res_status_ff, res_status_in;
   logic [pbht_pkg::VALUE_W-1:0] res_value_ff, res_value_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pbht_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [pbht_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [pbht_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                 req_fire;
   logic                 csr_wr;
   logic [MW-1:0]        key_mask;
   logic [MW-1:0]        key_masked;
   logic [45:0]          mod_prod;
   logic [31:0]          mod_rem;
   logic                 rsp_free;

   logic                 fill_we;
   logic [BW-1:0]        fill_waddr;
   logic [FW-1:0]        fill_wdata;
   logic [BW-1:0]        fill_raddr;
   logic [FW-1:0]        fill_rdata;

   logic [ENTRIES_IN_BUCKET-1:0] slot_we;
   logic [AW-1:0]        slot_waddr;
   logic [KVW-1:0]       slot_wdata;
   logic [AW-1:0]        slot_raddr;
   logic [KVW-1:0]       lane_rd [ENTRIES_IN_BUCKET];

   logic [FW:0]          fill_ext;
   logic [FW:0]          lo_pos;
   logic [FW:0]          hi_pos;
   logic                 scan_last;
   logic                 hit_any;
   logic [LW-1:0]        hit_lane;
   logic [LW-1:0]        last_lane;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                     (csr_paddr[2] == pbht_pkg::CSR_BIN_INDEX_BITS);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign key_mask   = MW'((16'd1 << bits_ff) - 16'd1);
   assign key_masked = req_chan.key[MW-1:0] & key_mask;

   // quotient estimate by reciprocal, low by at most one
   assign mod_prod = {31'd0, masked_ff} * {15'd0, RECIP};

   always_comb begin
      mod_rem = 32'(masked_ff) - 32'(mod_r_ff) * 32'(NUM_BINS);
      if (mod_rem >= 32'(NUM_BINS)) begin
         mod_rem = mod_rem - 32'(NUM_BINS);
      end
   end

   assign fill_ext  = {1'b0, fill_ff};
   assign lo_pos    = (FW+1)'(32'(b_ff) * ENTRIES_IN_BUCKET);
   assign hi_pos    = lo_pos + (FW+1)'(ENTRIES_IN_BUCKET);
   assign scan_last = hi_pos >= fill_ext;
   assign last_lane = LW'(fill_ext - lo_pos - (FW+1)'(1));

   always_comb begin
      hit_any  = 1'b0;
      hit_lane = '0;
      for (int j = ENTRIES_IN_BUCKET - 1; j >= 0; j--) begin
         if ((lo_pos + (FW+1)'(j)) < fill_ext &&
             lane_rd[j][KVW-1:pbht_pkg::VALUE_W] == key_ff) begin
            hit_any  = 1'b1;
            hit_lane = LW'(j);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbht_pkg::S_CLEAR: begin
            if (clr_ff == BW'(NUM_BINS - 1)) begin
               state_in = pbht_pkg::S_IDLE;
            end
         end
         pbht_pkg::S_IDLE: begin
            if (req_fire) begin
               if (pbht_pkg::mode_type'(req_chan.mode) == pbht_pkg::MODE_NONE) begin
                  state_in = pbht_pkg::S_DONE;
               end else if (POW2) begin
                  state_in = pbht_pkg::S_FILL;
               end else begin
                  state_in = pbht_pkg::S_MOD;
               end
            end
         end
         pbht_pkg::S_MOD: begin
            if (mod_cnt_ff == 4'd1) begin
               state_in = pbht_pkg::S_FILL;
            end
         end
         pbht_pkg::S_FILL:  state_in = pbht_pkg::S_FWAIT;
         pbht_pkg::S_FWAIT: state_in = pbht_pkg::S_SCAN;
         pbht_pkg::S_SCAN: begin
            if (scan_last) begin
               state_in = pbht_pkg::S_WRITE;
            end
         end
         pbht_pkg::S_WRITE: state_in = pbht_pkg::S_DONE;
         pbht_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = pbht_pkg::S_IDLE;
            end
         end
         default: state_in = pbht_pkg::S_IDLE;
      endcase
   end

   // memory controls and handshake outputs
   always_comb begin
      req_chan.ready = (state_ff == pbht_pkg::S_IDLE);
      fill_we    = 1'b0;
      fill_waddr = bin_ff;
      fill_wdata = fill_ff;
      fill_raddr = bin_ff;
      slot_we    = '0;
      slot_waddr = put_row_ff;
      slot_wdata = {key_ff, value_ff};
      slot_raddr = row_base_ff + AW'(b_ff) + AW'(1);
      case (state_ff)
         pbht_pkg::S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
         end
         pbht_pkg::S_FWAIT: begin
            slot_raddr = row_base_ff;
         end
         pbht_pkg::S_WRITE: begin
            case (mode_ff)
               pbht_pkg::MODE_PUT: begin
                  if (!found_ff && fill_ff != FW'(RUN)) begin
                     slot_we[put_lane_ff] = 1'b1;
                     fill_we    = 1'b1;
                     fill_wdata = fill_ff + FW'(1);
                  end
               end
               pbht_pkg::MODE_REMOVE: begin
                  if (found_ff) begin
                     slot_we[hole_lane_ff] = 1'b1;
                     slot_waddr = hole_row_ff;
                     slot_wdata = last_kv_ff;
                     fill_we    = 1'b1;
                     fill_wdata = fill_ff - FW'(1);
                  end
               end
               default: begin
                  fill_we = 1'b0;
               end
            endcase
         end
         default: begin
            fill_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      bits_in       = bits_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      masked_in     = masked_ff;
      mod_r_in      = mod_r_ff;
      mod_cnt_in    = mod_cnt_ff;
      bin_in        = bin_ff;
      row_base_in   = row_base_ff;
      fill_in       = fill_ff;
      b_in          = b_ff;
      found_in      = found_ff;
      hole_row_in   = hole_row_ff;
      hole_lane_in  = hole_lane_ff;
      hit_val_in    = hit_val_ff;
      last_kv_in    = last_kv_ff;
      put_row_in    = put_row_ff;
      put_lane_in   = put_lane_ff;
      clr_in        = clr_ff;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;

      if (csr_wr) begin
         bits_in = csr_pwdata[pbht_pkg::BITS_W-1:0];
      end

      case (state_ff)
         pbht_pkg::S_CLEAR: begin
            clr_in = clr_ff + BW'(1);
         end
         pbht_pkg::S_IDLE: begin
            if (req_fire) begin
               mode_in       = pbht_pkg::mode_type'(req_chan.mode);
               key_in        = req_chan.key;
               value_in      = req_chan.value;
               masked_in     = key_masked;
               mod_r_in      = '0;
               mod_cnt_in    = '0;
               bin_in        = BW'({1'b0, key_masked} & 16'(NUM_BINS - 1));
               res_status_in = pbht_pkg::STATUS_DONE;
               res_value_in  = '0;
            end
         end
         pbht_pkg::S_MOD: begin
            mod_cnt_in = mod_cnt_ff + 4'd1;
            if (mod_cnt_ff == '0) begin
               mod_r_in = RW'(mod_prod >> 30);
            end else begin
               bin_in = BW'(mod_rem);
            end
         end
         pbht_pkg::S_FILL: begin
            row_base_in = AW'(32'(bin_ff) * BUCKETS_IN_CHAIN);
         end
         pbht_pkg::S_FWAIT: begin
            fill_in  = fill_rdata;
            b_in     = '0;
            found_in = 1'b0;
         end
         pbht_pkg::S_SCAN: begin
            if (!found_ff && hit_any) begin
               found_in     = 1'b1;
               hole_row_in  = row_base_ff + AW'(b_ff);
               hole_lane_in = hit_lane;
               hit_val_in   = lane_rd[hit_lane][pbht_pkg::VALUE_W-1:0];
            end
            if (scan_last) begin
               if (fill_ff != '0) begin
                  last_kv_in = lane_rd[last_lane];
               end
               if (fill_ext < hi_pos) begin
                  put_row_in  = row_base_ff + AW'(b_ff);
                  put_lane_in = LW'(fill_ext - lo_pos);
               end else begin
                  put_row_in  = row_base_ff + AW'(b_ff) + AW'(1);
                  put_lane_in = '0;
               end
            end else begin
               b_in = b_ff + BCW'(1);
            end
         end
         pbht_pkg::S_WRITE: begin
            case (mode_ff)
               pbht_pkg::MODE_GET: begin
                  res_status_in = found_ff ? pbht_pkg::STATUS_DONE : pbht_pkg::STATUS_ABSENT;
                  res_value_in  = found_ff ? hit_val_ff : '0;
               end
               pbht_pkg::MODE_PUT: begin
                  res_value_in = '0;
                  if (found_ff) begin
                     res_status_in = pbht_pkg::STATUS_DUPLICATE;
                  end else if (fill_ff == FW'(RUN)) begin
                     res_status_in = pbht_pkg::STATUS_FULL;
                  end else begin
                     res_status_in = pbht_pkg::STATUS_DONE;
                     total_in      = total_ff + TW'(1);
                  end
               end
               pbht_pkg::MODE_REMOVE: begin
                  if (found_ff) begin
                     res_status_in = pbht_pkg::STATUS_DONE;
                     res_value_in  = hit_val_ff;
                     if (total_ff != '0) begin
                        total_in = total_ff - TW'(1);
                     end
                  end else begin
                     res_status_in = pbht_pkg::STATUS_ABSENT;
                     res_value_in  = '0;
                  end
               end
               default: begin
                  res_status_in = pbht_pkg::STATUS_DONE;
                  res_value_in  = '0;
               end
            endcase
         end
         pbht_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = pbht_pkg::COUNT_W'(total_ff);
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbht_pkg::S_CLEAR;
         bits_ff      <= pbht_pkg::BIN_BITS_RESET;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bits_ff      <= bits_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      masked_ff     <= masked_in;
      mod_r_ff      <= mod_r_in;
      mod_cnt_ff    <= mod_cnt_in;
      bin_ff        <= bin_in;
      row_base_ff   <= row_base_in;
      fill_ff       <= fill_in;
      b_ff          <= b_in;
      found_ff      <= found_in;
      hole_row_ff   <= hole_row_in;
      hole_lane_ff  <= hole_lane_in;
      hit_val_ff    <= hit_val_in;
      last_kv_ff    <= last_kv_in;
      put_row_ff    <= put_row_in;
      put_lane_ff   <= put_lane_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   pbht_ram #(
      .WIDTH (FW),
      .DEPTH (NUM_BINS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_addr (fill_raddr),
      .rd_data (fill_rdata)
   );

   for (genvar g = 0; g < ENTRIES_IN_BUCKET; g++) begin : g_lane
      pbht_ram #(
         .WIDTH (KVW),
         .DEPTH (ROWS)
      ) u_slot_ram (
         .clock   (clock),
         .wr_en   (slot_we[g]),
         .wr_addr (slot_waddr),
         .wr_data (slot_wdata),
         .rd_addr (slot_raddr),
         .rd_data (lane_rd[g])
      );
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.value_out   = rsp_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == pbht_pkg::CSR_BIN_INDEX_BITS) ?
                       pbht_pkg::CSR_DATA_W'(bits_ff) : '0;

endmodule

// File: src/pbht_ram.sv
// generic simple dual-port ram with registered read
module pbht_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pbht_checker.sv
// port-level checker for the hash table top and its bind
`include "assert_macros.svh"

module pbht_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [1:0]                       rsp_status,
   input logic [pbht_pkg::VALUE_W-1:0]     rsp_value_out
);

   `PBHT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `PBHT_ASSERT(a_one_busy, req_valid && req_ready |=> !req_ready, "request taken while busy")
   `PBHT_ASSERT(a_rsp_after_work, $rose(rsp_valid) |-> $past(!req_ready), "response without work")
   `PBHT_ASSERT(a_zero_value, rsp_valid && rsp_status != pbht_pkg::STATUS_DONE |-> rsp_value_out == '0, "value on failed request")
   `PBHT_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "response out of reset")

endmodule

bind packed_bucket_hash_table_top pbht_checker u_pbht_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_value_out (rsp_chan.value_out)
);

// File: bench/tb_top.sv
// self-checking testbench for the packed bucket hash table
`timescale 1ns / 1ps

module tb_top;

   localparam int BINS      = 1024;
   localparam int RUN       = 16;
   localparam int WDOG_MAX  = 20000;

   typedef struct packed {
      pbht_pkg::mode_type mode;
      logic [63:0]        key;
      logic [63:0]        value;
   } request_type;

   typedef struct packed {
      pbht_pkg::status_type status;
      logic [63:0]          value_out;
      logic [14:0]          entry_count;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [pbht_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [pbht_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [pbht_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   pbht_req_if req_chan ();
   pbht_rsp_if rsp_chan ();

   packed_bucket_hash_table_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [63:0] tbl_keys [BINS*RUN];
   logic [63:0] tbl_vals [BINS*RUN];
   int unsigned tbl_fill [BINS];
   int unsigned tbl_total;
   logic [3:0] tbl_bits;

   request_type  pending_requests [$];
   response_type expected_responses [$];
   logic [63:0] stored_keys [$];

   int unsigned send_idle_pct = 38, recv_idle_pct = 80;
   int errors = 0, mismatches = 0, responses_seen = 0, requests_sent = 0;
   int idle_cycles = 0;
   int status_hits [4];

   function automatic int unsigned bin_of(logic [63:0] key);
      logic [63:0] mask;
      mask = (64'd1 << tbl_bits) - 64'd1;
      return int'((key & mask) % BINS);
   endfunction

   function automatic response_type table_apply(request_type rq);
      response_type r;
      int unsigned b, base, pos, last;
      b = bin_of(rq.key);
      base = b * RUN;
      pos = RUN;
      r.status = pbht_pkg::STATUS_DONE;
      r.value_out = '0;
      if (rq.mode != pbht_pkg::MODE_NONE)
         for (int i = 0; i < tbl_fill[b] && i < RUN; i++)
            if (pos == RUN && tbl_keys[base+i] == rq.key) pos = i;
      case (rq.mode)
         pbht_pkg::MODE_GET: begin
            if (pos < RUN) r.value_out = tbl_vals[base+pos];
            else r.status = pbht_pkg::STATUS_ABSENT;
         end
         pbht_pkg::MODE_PUT: begin
            if (pos < RUN) r.status = pbht_pkg::STATUS_DUPLICATE;
            else if (tbl_fill[b] >= RUN) r.status = pbht_pkg::STATUS_FULL;
            else begin
               tbl_keys[base+tbl_fill[b]] = rq.key;
               tbl_vals[base+tbl_fill[b]] = rq.value;
               tbl_fill[b]++;
               tbl_total++;
            end
         end
         pbht_pkg::MODE_REMOVE: begin
            if (pos < RUN) begin
               last = base + tbl_fill[b] - 1;
               r.value_out = tbl_vals[base+pos];
               tbl_keys[base+pos] = tbl_keys[last];
               tbl_vals[base+pos] = tbl_vals[last];
               tbl_fill[b]--;
               if (tbl_total > 0) tbl_total--;
            end else r.status = pbht_pkg::STATUS_ABSENT;
         end
         default: ;
      endcase
      r.entry_count = tbl_total[14:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_responses.push_back(table_apply({pbht_pkg::mode_type'(req_chan.mode),
               req_chan.key, req_chan.value}));
            requests_sent++;
         end
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            request_type rq;
            rq = pending_requests.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.mode <= rq.mode;
            req_chan.key <= rq.key;
            req_chan.value <= rq.value;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            response_type want;
            responses_seen++;
            if (expected_responses.size() == 0) begin
               errors++;
               $display("unexpected response status=%0d", rsp_chan.status);
            end else begin
               want = expected_responses.pop_front();
               status_hits[want.status]++;
               if (rsp_chan.status !== want.status || rsp_chan.value_out !== want.value_out
                   || rsp_chan.entry_count !== want.entry_count) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st=%0d val=%h cnt=%0d got st=%0d val=%h cnt=%0d",
                        want.status, want.value_out, want.entry_count, rsp_chan.status,
                        rsp_chan.value_out, rsp_chan.entry_count);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [3:0] bits);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= {28'd0, bits};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      tbl_bits = bits;
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_chan.valid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void push_req(pbht_pkg::mode_type m, logic [63:0] k, logic [63:0] v);
      request_type rq;
      rq.mode = m; rq.key = k; rq.value = v;
      pending_requests.push_back(rq);
   endfunction

   // key near a small set of bins so runs fill up
   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 4 && stored_keys.size() > 0)
         return stored_keys[$urandom_range(stored_keys.size()-1)];
      k = rand64();
      if (sel < 8) k[9:0] = 10'($urandom_range(7));
      return k;
   endfunction

   task automatic random_phase(int n);
      logic [63:0] k;
      for (int i = 0; i < n; i++) begin
         k = pick_key();
         case ($urandom_range(19))
            0: push_req(pbht_pkg::MODE_NONE, k, rand64());
            1, 2, 3, 4, 5, 6, 7, 8: begin
               push_req(pbht_pkg::MODE_PUT, k, rand64());
               stored_keys.push_back(k);
               if (stored_keys.size() > 200) void'(stored_keys.pop_front());
            end
            9, 10, 11, 12, 13: push_req(pbht_pkg::MODE_GET, k, rand64());
            default: push_req(pbht_pkg::MODE_REMOVE, k, rand64());
         endcase
      end
   endtask

   initial begin
      tbl_total = 0;
      tbl_bits = pbht_pkg::BIN_BITS_RESET;
      foreach (tbl_fill[i]) tbl_fill[i] = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      req_chan.valid = 1'b0;
      req_chan.mode = pbht_pkg::MODE_GET;
      req_chan.key = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every mode, full bin, duplicates, absent keys
      push_req(pbht_pkg::MODE_GET, 64'd0, 64'd0);
      push_req(pbht_pkg::MODE_REMOVE, '1, 64'd0);
      push_req(pbht_pkg::MODE_PUT, 64'd0, '1);
      push_req(pbht_pkg::MODE_PUT, '1, 64'd0);
      push_req(pbht_pkg::MODE_PUT, 64'd0, 64'h5555_5555_5555_5555);
      push_req(pbht_pkg::MODE_GET, 64'd0, 64'd0);
      push_req(pbht_pkg::MODE_GET, '1, '1);
      push_req(pbht_pkg::MODE_NONE, 64'hAAAA_AAAA_AAAA_AAAA, '1);
      for (int i = 1; i <= 16; i++)
         push_req(pbht_pkg::MODE_PUT, {54'(i), 10'd5}, {32'(i), 32'hFFFF_FFFF});
      push_req(pbht_pkg::MODE_PUT, {54'd3, 10'd5}, 64'd1);
      push_req(pbht_pkg::MODE_REMOVE, {54'd2, 10'd5}, 64'd0);
      push_req(pbht_pkg::MODE_REMOVE, 64'd0, 64'd0);
      drain();

      // bin_index_bits settings from 0 to 15 and other handshake idle percentages, each with a random stretch
      csr_write(4'd0);
      random_phase(200);
      drain();
      csr_write(4'd15);
      random_phase(300);
      drain();
      csr_write(4'd3);
      random_phase(300);
      drain();
      csr_write(4'd10);
      send_idle_pct = 80; recv_idle_pct = 38;
      random_phase(500);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      csr_write(4'd1);
      random_phase(250);
      drain();
      csr_write(4'd10);
      random_phase(250);
      drain();

      $display("sent %0d requests, got %0d responses", requests_sent, responses_seen);
      $display("status mix done/absent/dup/full: %0d/%0d/%0d/%0d",
         status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors", errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+src
src/pbht_pkg.sv
src/pbht_if.sv
src/pbht_ram.sv
src/packed_bucket_hash_table_top.sv
src/pbht_checker.sv
bench/tb_top.sv
